// ===== hw/rtl/apsup_pkg.sv =====
// Package with the shared types, codes and constants of the arm position PID supervisor.
`timescale 1ns / 1ps
`default_nettype none
package apsup_pkg;

    // Function selector codes of an input word.
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_STOP   = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // Status codes reported in every result word.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ACTIVE    = 3'd1;
    localparam logic [2:0] ST_REACHED   = 3'd2;
    localparam logic [2:0] ST_ENC_ERR   = 3'd3;
    localparam logic [2:0] ST_LIMIT_ERR = 3'd4;
    localparam logic [2:0] ST_FAULT     = 3'd5;
    localparam logic [2:0] ST_DRIVE_ERR = 3'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOLERANCE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT  = 4'd7;

    // Configuration reset values.
    localparam logic [23:0]        RST_GAIN_P          = 24'd65536;
    localparam logic [23:0]        RST_GAIN_I          = 24'd0;
    localparam logic [23:0]        RST_GAIN_D          = 24'd0;
    localparam logic signed [31:0] RST_ANGLE_MIN       = -32'sd23040;
    localparam logic signed [31:0] RST_ANGLE_MAX       = 32'sd23040;
    localparam logic [15:0]        RST_REACH_TOLERANCE = 16'd256;
    localparam logic [22:0]        RST_RATE_LIMIT      = 23'd768000;
    localparam logic [22:0]        RST_INTEGRAL_LIMIT  = 23'd256000;

    // Integral step: round(|err| * gain_i * dt / (65536 * 1000)), saturated at 2^24.
    localparam logic [25:0] INT_DIVISOR  = 26'd65536000;
    localparam logic [25:0] INT_ROUND    = 26'd32768000;
    localparam logic [24:0] INT_SAT_STEP = 25'h1000000;
    localparam int          DIV_STEPS    = 24;

    // Division by 65536000 is (x >> 19) / 125, done as a multiply by 2^35 / 125
    // rounded up; exact for every numerator below 2^31.
    localparam logic [31:0] RECIP_125   = 32'h10624DD3;
    localparam int          RECIP_SHIFT = 35;

    // Input word.
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] target_angle;
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic [31:0]        now_ms;
        logic               encoder_ok;
        logic               fault_active;
        logic               drive_was_on;
        logic               drive_enable_ok;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [2:0]         status;
        logic               running;
        logic signed [23:0] speed_ref;
        logic               speed_ref_valid;
        logic signed [31:0] error_angle;
        logic               drive_claim;
        logic               drive_release;
        logic               speed_loop_off;
    } t_out_word;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_MUL_P, S_MUL_D, S_MUL_I, S_MUL_LO, S_MUL_HI,
        S_SAT, S_DIV, S_FINISH, S_RESULT
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE, MUL_P, MUL_D, MUL_I, MUL_LO, MUL_HI, MUL_Q
    } t_mul_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    decide;
        logic    begin_sample;
        t_mul_op mul_op;
        logic    sat_check;
        logic    finish;
        logic    load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sample_go;
        logic gi_zero;
        logic sat;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== hw/rtl/apsup_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface apsup_in_if;
    logic                valid;
    logic                ready;
    apsup_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface apsup_out_if;
    logic                 valid;
    logic                 ready;
    apsup_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface apsup_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [apsup_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/apsup_ctrl.sv =====
// Controller state machine that sequences the supervisor datapath.
`timescale 1ns / 1ps
`default_nettype none
module apsup_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire apsup_pkg::t_dp_status i_status,
    output apsup_pkg::t_dp_cmd         o_cmd
);

    apsup_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apsup_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            apsup_pkg::S_IDLE: begin
                if (i_in_valid) n_state = apsup_pkg::S_DECIDE;
            end
            apsup_pkg::S_DECIDE: begin
                n_state = i_status.sample_go ? apsup_pkg::S_MUL_P : apsup_pkg::S_RESULT;
            end
            apsup_pkg::S_MUL_P:  n_state = apsup_pkg::S_MUL_D;
            apsup_pkg::S_MUL_D: begin
                n_state = i_status.gi_zero ? apsup_pkg::S_FINISH : apsup_pkg::S_MUL_I;
            end
            apsup_pkg::S_MUL_I:  n_state = apsup_pkg::S_MUL_LO;
            apsup_pkg::S_MUL_LO: n_state = apsup_pkg::S_MUL_HI;
            apsup_pkg::S_MUL_HI: n_state = apsup_pkg::S_SAT;
            apsup_pkg::S_SAT: begin
                n_state = i_status.sat ? apsup_pkg::S_FINISH : apsup_pkg::S_DIV;
            end
            apsup_pkg::S_DIV:    n_state = apsup_pkg::S_FINISH;
            apsup_pkg::S_FINISH: n_state = apsup_pkg::S_RESULT;
            apsup_pkg::S_RESULT: begin
                if (i_status.out_free) n_state = apsup_pkg::S_IDLE;
            end
            default: n_state = apsup_pkg::S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_in_ready         = 1'b0;
        o_cmd              = '0;
        o_cmd.mul_op       = apsup_pkg::MUL_NONE;
        case (r_state)
            apsup_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            apsup_pkg::S_DECIDE: begin
                o_cmd.decide       = !i_status.sample_go;
                o_cmd.begin_sample = i_status.sample_go;
            end
            apsup_pkg::S_MUL_P:  o_cmd.mul_op = apsup_pkg::MUL_P;
            apsup_pkg::S_MUL_D:  o_cmd.mul_op = apsup_pkg::MUL_D;
            apsup_pkg::S_MUL_I:  o_cmd.mul_op = apsup_pkg::MUL_I;
            apsup_pkg::S_MUL_LO: o_cmd.mul_op = apsup_pkg::MUL_LO;
            apsup_pkg::S_MUL_HI: o_cmd.mul_op = apsup_pkg::MUL_HI;
            apsup_pkg::S_SAT:    o_cmd.sat_check = 1'b1;
            apsup_pkg::S_DIV:    o_cmd.mul_op = apsup_pkg::MUL_Q;
            apsup_pkg::S_FINISH: o_cmd.finish = 1'b1;
            apsup_pkg::S_RESULT: o_cmd.load_out = i_status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/apsup_dp.sv =====
// Datapath: configuration, loop state, shared multiplier, integral step and result register.
`timescale 1ns / 1ps
`default_nettype none
module apsup_dp #(
    parameter int SAMPLE_PERIOD_MS = 5,
    parameter int DIRECTION_SIGN   = 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire apsup_pkg::t_dp_cmd              i_cmd,
    output apsup_pkg::t_dp_status                o_status,
    input  wire apsup_pkg::t_in_word             i_in_word,
    input  wire logic                            i_cfg_fire,
    input  wire logic [apsup_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output apsup_pkg::t_out_word                 o_out_word
);

    // Saturate a 33-bit difference to 32 bits.
    function automatic logic signed [31:0] sat33(input logic [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        else r = $signed(v[31:0]);
        return r;
    endfunction

    // Configuration registers.
    logic [23:0]        r_gain_p, r_gain_i, r_gain_d;
    logic signed [31:0] r_angle_min, r_angle_max;
    logic [15:0]        r_reach_tol;
    logic [22:0]        r_rate_limit, r_int_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= apsup_pkg::RST_GAIN_P;
            r_gain_i     <= apsup_pkg::RST_GAIN_I;
            r_gain_d     <= apsup_pkg::RST_GAIN_D;
            r_angle_min  <= apsup_pkg::RST_ANGLE_MIN;
            r_angle_max  <= apsup_pkg::RST_ANGLE_MAX;
            r_reach_tol  <= apsup_pkg::RST_REACH_TOLERANCE;
            r_rate_limit <= apsup_pkg::RST_RATE_LIMIT;
            r_int_limit  <= apsup_pkg::RST_INTEGRAL_LIMIT;
        end else if (i_cfg_fire) begin
            case (i_cfg_index)
                apsup_pkg::CFG_GAIN_P:          r_gain_p     <= i_cfg_data[23:0];
                apsup_pkg::CFG_GAIN_I:          r_gain_i     <= i_cfg_data[23:0];
                apsup_pkg::CFG_GAIN_D:          r_gain_d     <= i_cfg_data[23:0];
                apsup_pkg::CFG_ANGLE_MIN:       r_angle_min  <= $signed(i_cfg_data);
                apsup_pkg::CFG_ANGLE_MAX:       r_angle_max  <= $signed(i_cfg_data);
                apsup_pkg::CFG_REACH_TOLERANCE: r_reach_tol  <= i_cfg_data[15:0];
                apsup_pkg::CFG_RATE_LIMIT:      r_rate_limit <= i_cfg_data[22:0];
                apsup_pkg::CFG_INTEGRAL_LIMIT:  r_int_limit  <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // Captured input word.
    apsup_pkg::t_in_word r_in;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= i_in_word;
    end

    // Loop state and result strobes.
    logic               r_active, n_active, r_self_en, n_self_en;
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_target, n_target, r_error, n_error, r_integ, n_integ;
    logic signed [23:0] r_output, n_output;
    logic [31:0]        r_last_tick, n_last_tick;
    logic               r_valid, n_valid, r_claim, n_claim;
    logic               r_release, n_release, r_loop_off, n_loop_off;

    // Working registers of a sample.
    logic signed [31:0] r_err;
    logic [31:0]        r_dt;
    logic [55:0]        r_pprod, r_dprod, r_iprod;
    logic [59:0]        r_lo, r_hi;
    logic [30:0]        r_num;
    logic [23:0]        r_quot;
    logic               r_sat;

    logic [31:0]        dt_now;
    logic signed [31:0] start_err, sample_err;
    logic               limit_bad, shut;

    assign dt_now     = r_in.now_ms - r_last_tick;
    assign start_err  = sat33({r_in.target_angle[31], r_in.target_angle}
                              - {r_in.position[31], r_in.position});
    assign sample_err = sat33({r_target[31], r_target} - {r_in.position[31], r_in.position});
    assign limit_bad  = (r_in.target_angle < r_angle_min) || (r_in.target_angle > r_angle_max);

    // Status toward the controller.
    logic [87:0] x_sum;
    logic        x_sat;
    assign x_sum = {r_hi, 28'b0} + {28'b0, r_lo} + 88'(apsup_pkg::INT_ROUND);
    assign x_sat = (x_sum >= (88'(apsup_pkg::INT_DIVISOR) << apsup_pkg::DIV_STEPS));

    assign o_status.sample_go = (r_in.func == apsup_pkg::FUNC_SAMPLE) && r_active
                                && !r_in.fault_active && r_in.encoder_ok
                                && (dt_now >= 32'(SAMPLE_PERIOD_MS));
    assign o_status.gi_zero   = (r_gain_i == '0);
    assign o_status.sat       = x_sat;
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    // Shared multiplier.
    logic [31:0] err_mag, spd_mag, mul_a, mul_b;
    logic [63:0] mul_res;
    assign err_mag = r_err[31] ? (~r_err + 32'd1) : r_err;
    assign spd_mag = r_in.speed[31] ? (~r_in.speed + 32'd1) : r_in.speed;

    always_comb begin
        case (i_cmd.mul_op)
            apsup_pkg::MUL_P: begin
                mul_a = err_mag;
                mul_b = {8'b0, r_gain_p};
            end
            apsup_pkg::MUL_D: begin
                mul_a = spd_mag;
                mul_b = {8'b0, r_gain_d};
            end
            apsup_pkg::MUL_I: begin
                mul_a = err_mag;
                mul_b = {8'b0, r_gain_i};
            end
            apsup_pkg::MUL_LO: begin
                mul_a = {4'b0, r_iprod[27:0]};
                mul_b = r_dt;
            end
            apsup_pkg::MUL_HI: begin
                mul_a = {4'b0, r_iprod[55:28]};
                mul_b = r_dt;
            end
            apsup_pkg::MUL_Q: begin
                mul_a = {1'b0, r_num};
                mul_b = apsup_pkg::RECIP_125;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_sample) begin
            r_err <= sample_err;
            r_dt  <= dt_now;
        end
        case (i_cmd.mul_op)
            apsup_pkg::MUL_P:  r_pprod <= mul_res[55:0];
            apsup_pkg::MUL_D:  r_dprod <= mul_res[55:0];
            apsup_pkg::MUL_I:  r_iprod <= mul_res[55:0];
            apsup_pkg::MUL_LO: r_lo    <= mul_res[59:0];
            apsup_pkg::MUL_HI: r_hi    <= mul_res[59:0];
            apsup_pkg::MUL_Q:  r_quot  <= mul_res[apsup_pkg::RECIP_SHIFT +: 24];
            default: ;
        endcase
        // Below saturation the rounded numerator fits in 50 bits; keep it shifted by 19.
        if (i_cmd.sat_check) begin
            r_sat <= x_sat;
            r_num <= x_sum[49:19];
        end
    end

    // Final combination of the P, I and D terms.
    logic [56:0]        p_rnd, d_rnd;
    logic [24:0]        step;
    logic signed [43:0] p_s, d_s, inc_s, isum_raw, isum, ilim_s, rlim_s;
    logic signed [43:0] sum_raw, sum_cl, sum_dir;
    logic               reached;

    always_comb begin
        p_rnd  = {1'b0, r_pprod} + 57'd32768;
        d_rnd  = {1'b0, r_dprod} + 57'd32768;
        p_s    = r_err[31] ? -$signed({3'b0, p_rnd[56:16]}) : $signed({3'b0, p_rnd[56:16]});
        d_s    = r_in.speed[31] ? -$signed({3'b0, d_rnd[56:16]})
                                : $signed({3'b0, d_rnd[56:16]});
        step   = r_sat ? apsup_pkg::INT_SAT_STEP : {1'b0, r_quot};
        inc_s  = r_err[31] ? -$signed({19'b0, step}) : $signed({19'b0, step});
        ilim_s = $signed({21'b0, r_int_limit});
        rlim_s = $signed({21'b0, r_rate_limit});
        isum_raw = $signed({{12{r_integ[31]}}, r_integ}) + inc_s;
        if (o_status.gi_zero) isum = '0;
        else if (isum_raw < -ilim_s) isum = -ilim_s;
        else if (isum_raw > ilim_s) isum = ilim_s;
        else isum = isum_raw;
        sum_raw = p_s + isum - d_s;
        if (sum_raw < -rlim_s) sum_cl = -rlim_s;
        else if (sum_raw > rlim_s) sum_cl = rlim_s;
        else sum_cl = sum_raw;
        if (DIRECTION_SIGN > 0) sum_dir = sum_cl;
        else if (DIRECTION_SIGN < 0) sum_dir = -sum_cl;
        else sum_dir = '0;
        reached = (err_mag <= {16'b0, r_reach_tol});
    end

    // Next loop state.
    always_comb begin
        n_active    = r_active;
        n_self_en   = r_self_en;
        n_status    = r_status;
        n_target    = r_target;
        n_error     = r_error;
        n_integ     = r_integ;
        n_output    = r_output;
        n_last_tick = r_last_tick;
        n_valid     = r_valid;
        n_claim     = r_claim;
        n_release   = r_release;
        n_loop_off  = r_loop_off;
        shut        = 1'b0;
        if (i_cmd.decide) begin
            n_valid    = 1'b0;
            n_claim    = 1'b0;
            n_release  = 1'b0;
            n_loop_off = 1'b0;
            case (r_in.func)
                apsup_pkg::FUNC_START: begin
                    n_target = r_in.target_angle;
                    if (limit_bad) begin
                        n_status = apsup_pkg::ST_LIMIT_ERR;
                        n_active = 1'b0;
                        n_error  = start_err;
                        shut     = 1'b1;
                    end else if (!r_in.encoder_ok) begin
                        n_status = apsup_pkg::ST_ENC_ERR;
                        n_active = 1'b0;
                        shut     = 1'b1;
                    end else if (r_in.fault_active) begin
                        n_status = apsup_pkg::ST_FAULT;
                        n_active = 1'b0;
                        shut     = 1'b1;
                    end else if (!r_in.drive_was_on && !r_in.drive_enable_ok) begin
                        n_status = apsup_pkg::ST_DRIVE_ERR;
                        n_active = 1'b0;
                        shut     = 1'b1;
                    end else begin
                        n_self_en   = !r_in.drive_was_on;
                        n_claim     = !r_in.drive_was_on;
                        n_active    = 1'b1;
                        n_status    = apsup_pkg::ST_ACTIVE;
                        n_integ     = '0;
                        n_output    = '0;
                        n_error     = start_err;
                        n_last_tick = r_in.now_ms;
                    end
                end
                apsup_pkg::FUNC_STOP: begin
                    n_active = 1'b0;
                    n_status = apsup_pkg::ST_IDLE;
                    n_output = '0;
                    n_integ  = '0;
                    shut     = 1'b1;
                end
                apsup_pkg::FUNC_SAMPLE: begin
                    // A too-early sample with no fault or encoder loss keeps the loop state.
                    if (r_active && r_in.fault_active) begin
                        n_active = 1'b0;
                        n_status = apsup_pkg::ST_FAULT;
                        shut     = 1'b1;
                    end else if (r_active && !r_in.encoder_ok) begin
                        n_active = 1'b0;
                        n_status = apsup_pkg::ST_ENC_ERR;
                        shut     = 1'b1;
                    end
                end
                default: ;
            endcase
            if (shut) begin
                n_loop_off = 1'b1;
                if (r_self_en) begin
                    n_release = 1'b1;
                    n_self_en = 1'b0;
                end
            end
        end
        if (i_cmd.begin_sample) begin
            n_last_tick = r_in.now_ms;
            n_error     = sample_err;
        end
        if (i_cmd.finish) begin
            n_integ    = isum[31:0];
            n_output   = sum_dir[23:0];
            n_status   = reached ? apsup_pkg::ST_REACHED : apsup_pkg::ST_ACTIVE;
            n_valid    = 1'b1;
            n_claim    = 1'b0;
            n_release  = 1'b0;
            n_loop_off = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_self_en   <= 1'b0;
            r_status    <= apsup_pkg::ST_IDLE;
            r_target    <= '0;
            r_error     <= '0;
            r_integ     <= '0;
            r_output    <= '0;
            r_last_tick <= '0;
            r_valid     <= 1'b0;
            r_claim     <= 1'b0;
            r_release   <= 1'b0;
            r_loop_off  <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_self_en   <= n_self_en;
            r_status    <= n_status;
            r_target    <= n_target;
            r_error     <= n_error;
            r_integ     <= n_integ;
            r_output    <= n_output;
            r_last_tick <= n_last_tick;
            r_valid     <= n_valid;
            r_claim     <= n_claim;
            r_release   <= n_release;
            r_loop_off  <= n_loop_off;
        end
    end

    // Result register: holds a finished word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_word.status          <= r_status;
            o_out_word.running         <= r_active;
            o_out_word.speed_ref       <= r_output;
            o_out_word.speed_ref_valid <= r_valid;
            o_out_word.error_angle     <= r_error;
            o_out_word.drive_claim     <= r_claim;
            o_out_word.drive_release   <= r_release;
            o_out_word.speed_loop_off  <= r_loop_off;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/arm_position_pid_supervisor_core.sv =====
// Top level of the arm position PID supervisor.
//
// Each input word gives exactly one result word. Start, stop, other selectors and samples
// that do not run the loop pass the capture, decide and result states. A looping sample
// uses one shared 32x32 multiplier for the P and D products, then, if gain_i is not zero,
// for the I and two dt products and, unless the integral step saturates, for its division
// by a constant as one reciprocal multiply. A finished word waits in the output register
// while the next input word is accepted and processed. Configuration writes are taken in
// any cycle and should be made only while the block is idle. Angles and speeds are signed
// Q23.8, gains unsigned Q8.16, the speed reference Q15.8.
`timescale 1ns / 1ps
`default_nettype none
module arm_position_pid_supervisor_core #(
    parameter int SAMPLE_PERIOD_MS = 5,
    parameter int DIRECTION_SIGN   = 1
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    apsup_in_if.sink     i_in,
    apsup_out_if.source  o_out,
    apsup_cfg_if.sink    i_cfg
);

    apsup_pkg::t_dp_cmd    cmd;
    apsup_pkg::t_dp_status status;
    logic                  in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // Sequencer.
    apsup_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic, state and result register.
    apsup_dp #(
        .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS),
        .DIRECTION_SIGN   (DIRECTION_SIGN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_word   (i_in.data),
        .i_cfg_fire  (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_word  (o_out.data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/apsup_checker.sv =====
// Checker on the result port of the supervisor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module apsup_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire apsup_pkg::t_out_word i_out_word
);

    // A word that is not taken stays offered unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word dropped or changed while stalled");

    // Claiming the drive only happens on a successful start.
    a_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.drive_claim |->
            i_out_word.running && (i_out_word.status == apsup_pkg::ST_ACTIVE))
        else $error("drive claimed without an active loop");

    // A new speed reference comes only from a running loop that stays on.
    a_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.speed_ref_valid |->
            i_out_word.running && !i_out_word.speed_loop_off
            && ((i_out_word.status == apsup_pkg::ST_ACTIVE)
                || (i_out_word.status == apsup_pkg::ST_REACHED)))
        else $error("speed reference outside an active loop");

    // Shutting the loop off leaves the block stopped.
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.speed_loop_off |->
            !i_out_word.running && !i_out_word.drive_claim)
        else $error("loop shut off while still running");

    // The drive is released only as part of a shut-off.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_word.drive_release |-> i_out_word.speed_loop_off)
        else $error("drive released without shutting the loop off");

endmodule

bind arm_position_pid_supervisor_core apsup_checker u_apsup_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.data)
);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench of the arm position PID supervisor core.
`timescale 1ns / 1ps
module testbench;
    import apsup_pkg::*;

    localparam int  PERIOD_MS   = 5;
    localparam int  DIR_SIGN    = 1;
    localparam int  RAND_PHASES = 7;
    localparam int  RAND_ITEMS  = 122;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  DRAIN_WAIT  = 60;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word e;
    } stim_row_t;

    typedef struct {
        t_out_word pred;
        bit        typed;
        t_out_word given;
    } expect_t;

    typedef struct {
        bit        typed;
        t_out_word e;
    } note_t;

    logic i_clk;
    logic i_rst_n;

    apsup_in_if  in_ch ();
    apsup_out_if out_ch ();
    apsup_cfg_if cfg_ch ();

    arm_position_pid_supervisor_core #(
        .SAMPLE_PERIOD_MS(PERIOD_MS),
        .DIRECTION_SIGN(DIR_SIGN)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg(cfg_ch)
    );

    // Local copy of the configuration registers.
    logic [23:0]        c_gp   = RST_GAIN_P;
    logic [23:0]        c_gi   = RST_GAIN_I;
    logic [23:0]        c_gd   = RST_GAIN_D;
    logic signed [31:0] c_amin = RST_ANGLE_MIN;
    logic signed [31:0] c_amax = RST_ANGLE_MAX;
    logic [15:0]        c_tol  = RST_REACH_TOLERANCE;
    logic [22:0]        c_rate = RST_RATE_LIMIT;
    logic [22:0]        c_ilim = RST_INTEGRAL_LIMIT;

    // Local copy of the controller state.
    bit                 m_active   = 0;
    bit                 m_self_en  = 0;
    logic [2:0]         m_status   = ST_IDLE;
    logic signed [31:0] m_target   = 0;
    logic signed [31:0] m_err      = 0;
    logic signed [23:0] m_out      = 0;
    logic signed [31:0] m_integral = 0;
    logic [31:0]        m_tick     = 0;

    expect_t   pending_q[$];
    note_t     note_q[$];
    stim_row_t plan_q[$];

    int fails = 0;
    int cycles = 0;
    int accepted_words = 0;
    int burst_left = 0;

    // Generator-side view used to shape well-formed sequences.
    logic [31:0]        gen_tick = 0;
    logic signed [31:0] gen_target = 0;

    // Clock.
    initial i_clk = 0;
    always #6 i_clk = ~i_clk;

    // Run length guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint unsigned magnitude(longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v < -64'sd2147483648) return 32'sh80000000;
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        return v[31:0];
    endfunction

    // Q8.16 gain product, rounded half away from zero on the magnitude.
    function automatic longint gain_mul(longint a, logic [23:0] g);
        longint unsigned r;
        r = (magnitude(a) * longint'(g) + 64'd32768) >> 16;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic void cut_loop(inout bit rel, inout bit off);
        off = 1;
        if (m_self_en) begin
            rel = 1;
            m_self_en = 0;
        end
    endfunction

    // Expected result word of one accepted input word; advances the local state.
    function automatic t_out_word predict_word(t_in_word w);
        longint tgt, pos, spd, e, isum, sum, inc;
        longint unsigned prod, step, lim, dtl;
        logic [31:0] dt;
        bit vld, cl, rl, off;
        t_out_word r;
        tgt = longint'($signed(w.target_angle));
        pos = longint'($signed(w.position));
        spd = longint'($signed(w.speed));
        vld = 0; cl = 0; rl = 0; off = 0;
        case (w.func)
            FUNC_START: begin
                m_target = w.target_angle;
                if (tgt < longint'(c_amin) || tgt > longint'(c_amax)) begin
                    m_status = ST_LIMIT_ERR; m_active = 0;
                    m_err = sat32(tgt - pos);
                    cut_loop(rl, off);
                end else if (!w.encoder_ok) begin
                    m_status = ST_ENC_ERR; m_active = 0;
                    cut_loop(rl, off);
                end else if (w.fault_active) begin
                    m_status = ST_FAULT; m_active = 0;
                    cut_loop(rl, off);
                end else if (!w.drive_was_on && !w.drive_enable_ok) begin
                    m_status = ST_DRIVE_ERR; m_active = 0;
                    cut_loop(rl, off);
                end else begin
                    m_self_en = !w.drive_was_on;
                    cl = !w.drive_was_on;
                    m_active = 1;
                    m_status = ST_ACTIVE;
                    m_integral = 0;
                    m_out = 0;
                    m_err = sat32(tgt - pos);
                    m_tick = w.now_ms;
                end
            end
            FUNC_STOP: begin
                m_active = 0; m_status = ST_IDLE;
                m_out = 0; m_integral = 0;
                cut_loop(rl, off);
            end
            FUNC_SAMPLE: begin
                if (m_active) begin
                    if (w.fault_active) begin
                        m_active = 0; m_status = ST_FAULT;
                        cut_loop(rl, off);
                    end else if (!w.encoder_ok) begin
                        m_active = 0; m_status = ST_ENC_ERR;
                        cut_loop(rl, off);
                    end else begin
                        dt = w.now_ms - m_tick;
                        if (dt >= PERIOD_MS) begin
                            m_tick = w.now_ms;
                            e = longint'(sat32(longint'(m_target) - pos));
                            m_err = e[31:0];
                            if (c_gi != 0) begin
                                prod = magnitude(e) * longint'(c_gi);
                                lim = 64'd1000 * 64'd65536 * (64'd1 << 24);
                                dtl = longint'(dt);
                                if (prod != 0 && dtl > lim / prod)
                                    step = 64'd1 << 24;
                                else
                                    step = (prod * dtl + 64'd32768000) / 64'd65536000;
                                inc = (e < 0) ? -longint'(step) : longint'(step);
                                isum = longint'(m_integral) + inc;
                                if (isum < -longint'(c_ilim)) isum = -longint'(c_ilim);
                                if (isum > longint'(c_ilim)) isum = longint'(c_ilim);
                            end else begin
                                isum = 0;
                            end
                            m_integral = isum[31:0];
                            sum = gain_mul(e, c_gp) + isum - gain_mul(spd, c_gd);
                            m_status = (magnitude(e) <= longint'(c_tol)) ? ST_REACHED : ST_ACTIVE;
                            if (sum < -longint'(c_rate)) sum = -longint'(c_rate);
                            if (sum > longint'(c_rate)) sum = longint'(c_rate);
                            sum = sum * DIR_SIGN;
                            m_out = sum[23:0];
                            vld = 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.status          = m_status;
        r.running         = m_active;
        r.speed_ref       = m_out;
        r.speed_ref_valid = vld;
        r.error_angle     = m_err;
        r.drive_claim     = cl;
        r.drive_release   = rl;
        r.speed_loop_off  = off;
        return r;
    endfunction

    // Field-by-field comparison of one result word.
    function automatic void check_word(t_out_word want, t_out_word got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); fails++;
        end
        if (got.running !== want.running) begin
            $error("running: expected %0d, got %0d", want.running, got.running); fails++;
        end
        if (got.speed_ref !== want.speed_ref) begin
            $error("speed_ref: expected %0d, got %0d", want.speed_ref, got.speed_ref);
            fails++;
        end
        if (got.speed_ref_valid !== want.speed_ref_valid) begin
            $error("speed_ref_valid: expected %0d, got %0d",
                   want.speed_ref_valid, got.speed_ref_valid);
            fails++;
        end
        if (got.error_angle !== want.error_angle) begin
            $error("error_angle: expected %0d, got %0d", want.error_angle, got.error_angle);
            fails++;
        end
        if (got.drive_claim !== want.drive_claim) begin
            $error("drive_claim: expected %0d, got %0d", want.drive_claim, got.drive_claim);
            fails++;
        end
        if (got.drive_release !== want.drive_release) begin
            $error("drive_release: expected %0d, got %0d",
                   want.drive_release, got.drive_release);
            fails++;
        end
        if (got.speed_loop_off !== want.speed_loop_off) begin
            $error("speed_loop_off: expected %0d, got %0d",
                   want.speed_loop_off, got.speed_loop_off);
            fails++;
        end
    endfunction

    // Input monitor: predict each accepted word.
    always @(posedge i_clk) begin
        expect_t x;
        note_t n;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            n = note_q.pop_front();
            x.pred = predict_word(in_ch.data);
            x.typed = n.typed;
            x.given = n.e;
            pending_q.push_back(x);
            accepted_words <= accepted_words + 1;
        end
    end

    // Result monitor: compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        expect_t x;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                $error("result word with no prediction waiting");
                fails++;
            end else begin
                x = pending_q.pop_front();
                check_word(x.pred, out_ch.data);
                if (x.typed) check_word(x.given, out_ch.data);
            end
        end
    end

    // Receiver: stall patterns that change over time, plus one long hold-off.
    initial begin
        int mode;
        int span;
        int hold;
        bit held;
        out_ch.ready = 0;
        mode = 0; span = 0; hold = 0; held = 0;
        forever begin
            @(negedge i_clk);
            if (!held && accepted_words >= 300) begin
                held = 1;
                hold = 600;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(50, 250);
            end
            span--;
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= (($urandom & 3) != 0);
                    default: out_ch.ready <= (($urandom & 3) == 0);
                endcase
            end
        end
    end

    // Offer one input word in bursts with random gaps, and wait for its acceptance.
    task automatic send_word(t_in_word w, bit typed, t_out_word e);
        int gap;
        note_t n;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        n.typed = typed;
        n.e = e;
        note_q.push_back(n);
        in_ch.valid <= 1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // Wait until every prediction has been matched and the block has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:          c_gp = val[23:0];
            CFG_GAIN_I:          c_gi = val[23:0];
            CFG_GAIN_D:          c_gd = val[23:0];
            CFG_ANGLE_MIN:       c_amin = val;
            CFG_ANGLE_MAX:       c_amax = val;
            CFG_REACH_TOLERANCE: c_tol = val[15:0];
            CFG_RATE_LIMIT:      c_rate = val[22:0];
            CFG_INTEGRAL_LIMIT:  c_ilim = val[22:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic apply_setting(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                                 logic [31:0] amin, logic [31:0] amax, logic [31:0] tol,
                                 logic [31:0] rate, logic [31:0] ilim);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_ANGLE_MIN, amin);
        write_reg(CFG_ANGLE_MAX, amax);
        write_reg(CFG_REACH_TOLERANCE, tol);
        write_reg(CFG_RATE_LIMIT, rate);
        write_reg(CFG_INTEGRAL_LIMIT, ilim);
    endtask

    function automatic t_in_word make_word(logic [1:0] f, logic [31:0] tgt, logic [31:0] pos,
                                           logic [31:0] spd, logic [31:0] now, bit enc,
                                           bit flt, bit was, bit en);
        t_in_word w;
        w.func = f; w.target_angle = tgt; w.position = pos; w.speed = spd;
        w.now_ms = now; w.encoder_ok = enc; w.fault_active = flt;
        w.drive_was_on = was; w.drive_enable_ok = en;
        return w;
    endfunction

    function automatic t_out_word make_result(logic [2:0] st, bit run, logic [23:0] sref,
                                              bit vld, logic [31:0] err, bit cl, bit rl,
                                              bit off);
        t_out_word r;
        r.status = st; r.running = run; r.speed_ref = sref; r.speed_ref_valid = vld;
        r.error_angle = err; r.drive_claim = cl; r.drive_release = rl; r.speed_loop_off = off;
        return r;
    endfunction

    function automatic void add_row(t_in_word w, bit typed, t_out_word e);
        stim_row_t r;
        r.w = w; r.typed = typed; r.e = e;
        plan_q.push_back(r);
    endfunction

    // Random 32-bit value inside [lo, hi], both inclusive.
    function automatic logic [31:0] pick_between(longint lo, longint hi);
        longint unsigned span;
        longint v;
        span = longint'(hi - lo) + 1;
        v = lo + longint'({$urandom, $urandom} % span);
        return v[31:0];
    endfunction

    // One random input word, mostly a well-formed control sequence.
    function automatic t_in_word random_word();
        t_in_word w;
        int sel;
        int scale;
        logic [31:0] off;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) gen_tick = gen_tick + $urandom;
        else gen_tick = gen_tick + $urandom_range(0, 9);
        w = make_word(FUNC_SAMPLE, $urandom, $urandom, $urandom, gen_tick,
                      $urandom_range(0, 99) < 97, $urandom_range(0, 99) < 3,
                      $urandom_range(0, 1), $urandom_range(0, 1));
        if (sel < 10) begin
            w.func = FUNC_START;
            if (c_amin <= c_amax && $urandom_range(0, 99) < 85)
                w.target_angle = pick_between(c_amin, c_amax);
            w.encoder_ok = $urandom_range(0, 99) < 90;
            w.fault_active = $urandom_range(0, 99) < 10;
            w.drive_enable_ok = $urandom_range(0, 99) < 85;
            gen_target = w.target_angle;
        end else if (sel < 14) begin
            w.func = FUNC_STOP;
        end else if (sel < 17) begin
            w.func = FUNC_NONE;
        end
        // Position near the target with a random scale of offset, sometimes anywhere.
        if ($urandom_range(0, 99) < 90) begin
            scale = $urandom_range(0, 20);
            off = $urandom_range(0, 4095) - 2048;
            w.position = gen_target + (($signed(off) <<< scale) >>> 10);
        end
        if ($urandom_range(0, 99) < 85)
            w.speed = $urandom_range(0, 65535) - 32768;
        return w;
    endfunction

    // Directed rows: reset state, limit checks, timing, faults and extremes.
    function automatic void build_plan();
        t_out_word none;
        none = make_result(ST_IDLE, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 10, 1, 0, 0, 1), 1, none);
        add_row(make_word(FUNC_STOP, 0, 0, 0, 10, 1, 0, 0, 1), 1,
                make_result(ST_IDLE, 0, 0, 0, 0, 0, 0, 1));
        add_row(make_word(FUNC_START, 30000, 1000, 0, 10, 1, 0, 0, 1), 1,
                make_result(ST_LIMIT_ERR, 0, 0, 0, 29000, 0, 0, 1));
        add_row(make_word(FUNC_NONE, $urandom, $urandom, $urandom, $urandom, 1, 1, 1, 1), 1,
                make_result(ST_LIMIT_ERR, 0, 0, 0, 29000, 0, 0, 0));
        add_row(make_word(FUNC_START, 256, 0, 0, 100, 1, 0, 0, 1), 1,
                make_result(ST_ACTIVE, 1, 0, 0, 256, 1, 0, 0));
        // Sample before the period has passed.
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 104, 1, 0, 0, 0), 1,
                make_result(ST_ACTIVE, 1, 0, 0, 256, 0, 0, 0));
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 105, 1, 0, 0, 0), 1,
                make_result(ST_REACHED, 1, 256, 1, 256, 0, 0, 0));
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 120, 1, 1, 0, 0), 1,
                make_result(ST_FAULT, 0, 256, 0, 256, 0, 1, 1));
        // Start failures: drive, encoder, fault, target -2^31; start on lower bound.
        add_row(make_word(FUNC_START, 100, 0, 0, 130, 1, 0, 0, 0), 0, none);
        add_row(make_word(FUNC_START, 100, 0, 0, 130, 0, 1, 1, 1), 0, none);
        add_row(make_word(FUNC_START, 100, 0, 0, 130, 1, 1, 1, 1), 0, none);
        add_row(make_word(FUNC_START, 32'h80000000, 32'h7FFFFFFF, 0, 130, 1, 0, 0, 1), 0, none);
        add_row(make_word(FUNC_START, -23040, 32'h7FFFFFFF, 0, 140, 1, 0, 0, 1), 0, none);
        // Saturated error, full-scale speed.
        add_row(make_word(FUNC_SAMPLE, 0, 32'h7FFFFFFF, 32'h80000000, 150, 1, 0, 1, 1), 0, none);
        add_row(make_word(FUNC_SAMPLE, 0, 32'h80000000, 32'h7FFFFFFF, 160, 1, 0, 1, 1), 0, none);
        // Repeated start with the drive already on drops the claim.
        add_row(make_word(FUNC_START, 23040, 0, 0, 32'hFFFFFFFE, 1, 0, 1, 0), 0, none);
        // Tick wrap, then encoder loss while active.
        add_row(make_word(FUNC_SAMPLE, 0, 23000, 32'hFFFFFFFF, 3, 1, 0, 0, 0), 0, none);
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 20, 0, 0, 0, 0), 0, none);
        add_row(make_word(FUNC_START, 0, 32'hFFFFFFFF, 0, 30, 1, 0, 0, 1), 0, none);
        add_row(make_word(FUNC_STOP, 32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 0, 1, 1, 0), 0, none);
        add_row(make_word(FUNC_SAMPLE, 0, 0, 0, 40, 1, 0, 0, 1), 0, none);
    endfunction

    // Main sequence.
    initial begin
        t_out_word blank;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        blank = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        repeat (3) @(posedge i_clk);

        build_plan();
        foreach (plan_q[k]) send_word(plan_q[k].w, plan_q[k].typed, plan_q[k].e);

        for (int p = 1; p <= RAND_PHASES; p++) begin
            wait_idle();
            case (p)
                1: apply_setting(65536, 20000, 3000, -46080, 46080, 64, 768000, 256000);
                2: apply_setting(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'h80000000,
                                 32'h7FFFFFFF, 32'hFFFF, 32'h7FFFFF, 32'h7FFFFF);
                3: apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
                4: apply_setting(200000, 1, 0, 1000, -1000, 512, 100000, 5000);
                5: apply_setting(131072, 5000000, 65536, -2000000, 2000000, 1024,
                                 8000000, 4000000);
                default: apply_setting($urandom, $urandom, $urandom,
                                       -$urandom_range(0, 32'h7FFFFFF),
                                       $urandom_range(0, 32'h7FFFFFF),
                                       $urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < RAND_ITEMS; k++) send_word(random_word(), 0, blank);
        end

        wait_idle();
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
